[design/bsc_pkg.sv]
// Shared types and codes for the deadlock-avoidance safety check.
// Holds the request and result records, command and register codes, and scan states.
// Depends on nothing; bsc_scan and the core use it by scoped name.
package bsc_pkg;

	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUM_PROCESSES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUM_RESOURCES = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  process_index;
		logic [2:0]  resource_index;
		logic [15:0] alloc_value;
		logic [15:0] max_value;
		logic [15:0] avail_value;
	} request_t;

	typedef struct packed {
		logic       safe;
		logic [3:0] granted_process;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_CHECK,
		ST_ADD,
		ST_EMIT,
		ST_UNSAFE
	} scan_state_t;

endpackage

[design/bsc_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Used for the allocation/maximum table and the safe-sequence store.
// Depends on nothing.
module bsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[design/bsc_scan.sv]
// Scan sequencer of the safety check: walks the table RAM process by process,
// keeps the working availability and finished marks, and emits the safe sequence.
// Depends on bsc_pkg and bsc_ram.
module bsc_scan #(
	parameter int MAX_PROCESSES = 16,
	parameter int MAX_RESOURCES = 8,
	parameter int AMOUNT_WIDTH  = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      go,
	input  logic [$clog2(MAX_PROCESSES+1)-1:0]        np,
	input  logic [$clog2(MAX_RESOURCES+1)-1:0]        nr,
	input  logic [MAX_RESOURCES-1:0][AMOUNT_WIDTH-1:0] avail,
	output logic [((MAX_PROCESSES*MAX_RESOURCES > 1) ?
		$clog2(MAX_PROCESSES*MAX_RESOURCES) : 1)-1:0] tbl_raddr,
	input  logic [2*AMOUNT_WIDTH-1:0]                 tbl_rdata,
	output logic                                      busy,
	output logic                                      result_valid,
	output bsc_pkg::result_t                          result
);

	localparam int PW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int CNTW   = $clog2(MAX_PROCESSES+1);
	localparam int RCW    = $clog2(MAX_RESOURCES+1);
	localparam int WW     = AMOUNT_WIDTH + $clog2(MAX_PROCESSES+1);
	localparam int TDEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	bsc_pkg::scan_state_t state_q, state_d;

	logic [PW-1:0]            p_q;
	logic [RCW-1:0]           r_q;
	logic [CNTW-1:0]          count_q;
	logic [CNTW-1:0]          k_q;
	logic                     fail_q;
	logic                     progress_q;
	logic [MAX_PROCESSES-1:0] finished_q;
	logic [WW-1:0]            work_q [MAX_RESOURCES];

	logic          rd_vld_s1;
	logic [RW-1:0] rd_r_s1;
	logic          rd_last_s1;
	logic          em_vld_s1;
	logic          em_last_s1;

	logic             result_valid_q;
	bsc_pkg::result_t result_q;

	logic [AMOUNT_WIDTH-1:0] alloc_s1;
	logic [AMOUNT_WIDTH-1:0] max_s1;
	logic                    fit_s1;
	logic                    fits_all;
	logic                    last_p;
	logic                    pass_again;
	logic                    row_done;
	logic                    grant;
	logic                    p_step;
	logic                    rd_issue;
	logic                    em_issue;
	logic [PW-1:0]           seq_rdata;
	bsc_pkg::scan_state_t    adv_state;
	bsc_pkg::scan_state_t    end_state;

	assign alloc_s1 = tbl_rdata[2*AMOUNT_WIDTH-1:AMOUNT_WIDTH];
	assign max_s1   = tbl_rdata[AMOUNT_WIDTH-1:0];

	// need <= work  <=>  max <= work + alloc, all unsigned
	assign fit_s1 = ((WW+1)'(max_s1)) <= ((WW+1)'(work_q[rd_r_s1]) + (WW+1)'(alloc_s1));
	assign fits_all = !fail_q && fit_s1;

	assign last_p     = ((CNTW+1)'(p_q) + (CNTW+1)'(1)) == (CNTW+1)'(np);
	assign pass_again = progress_q && (count_q < np);
	assign row_done   = rd_vld_s1 && rd_last_s1;
	assign grant      = (state_q == bsc_pkg::ST_CHECK) && row_done && fits_all;
	assign p_step     = ((state_q == bsc_pkg::ST_PICK) && finished_q[p_q])
		|| ((state_q == bsc_pkg::ST_CHECK) && row_done && !fits_all)
		|| ((state_q == bsc_pkg::ST_ADD) && row_done);

	always_comb begin
		if (pass_again) begin
			end_state = bsc_pkg::ST_PICK;
		end else if (count_q == np) begin
			end_state = bsc_pkg::ST_EMIT;
		end else begin
			end_state = bsc_pkg::ST_UNSAFE;
		end
		adv_state = last_p ? end_state : bsc_pkg::ST_PICK;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsc_pkg::ST_IDLE: begin
				if (go) begin
					state_d = bsc_pkg::ST_PICK;
				end
			end
			bsc_pkg::ST_PICK: begin
				state_d = finished_q[p_q] ? adv_state : bsc_pkg::ST_CHECK;
			end
			bsc_pkg::ST_CHECK: begin
				if (row_done) begin
					state_d = fits_all ? bsc_pkg::ST_ADD : adv_state;
				end
			end
			bsc_pkg::ST_ADD: begin
				if (row_done) begin
					state_d = adv_state;
				end
			end
			bsc_pkg::ST_EMIT: begin
				if ((k_q == np) && !em_vld_s1) begin
					state_d = bsc_pkg::ST_IDLE;
				end
			end
			bsc_pkg::ST_UNSAFE: begin
				state_d = bsc_pkg::ST_IDLE;
			end
			default: begin
				state_d = bsc_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy     = (state_q != bsc_pkg::ST_IDLE);
		rd_issue = ((state_q == bsc_pkg::ST_CHECK) || (state_q == bsc_pkg::ST_ADD)) && (r_q < nr);
		em_issue = (state_q == bsc_pkg::ST_EMIT) && (k_q < np);
		tbl_raddr = TW'(int'(p_q) * MAX_RESOURCES + int'(r_q[RW-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bsc_pkg::ST_IDLE;
			p_q            <= '0;
			r_q            <= '0;
			count_q        <= '0;
			k_q            <= '0;
			fail_q         <= 1'b0;
			progress_q     <= 1'b0;
			finished_q     <= '0;
			rd_vld_s1      <= 1'b0;
			em_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			rd_vld_s1      <= rd_issue;
			em_vld_s1      <= em_issue;
			result_valid_q <= em_vld_s1 || (state_q == bsc_pkg::ST_UNSAFE);

			if ((state_q == bsc_pkg::ST_IDLE) && go) begin
				p_q        <= '0;
				count_q    <= '0;
				k_q        <= '0;
				progress_q <= 1'b0;
				finished_q <= '0;
			end
			if ((state_q == bsc_pkg::ST_PICK) && !finished_q[p_q]) begin
				r_q    <= '0;
				fail_q <= 1'b0;
			end
			if (rd_issue) begin
				r_q <= r_q + RCW'(1);
			end
			if ((state_q == bsc_pkg::ST_CHECK) && rd_vld_s1 && !fit_s1) begin
				fail_q <= 1'b1;
			end
			if (grant) begin
				r_q             <= '0;
				finished_q[p_q] <= 1'b1;
				count_q         <= count_q + CNTW'(1);
				progress_q      <= 1'b1;
			end
			// advance to the next process, wrapping into a new pass
			if (p_step) begin
				if (last_p) begin
					p_q        <= '0;
					progress_q <= 1'b0;
				end else begin
					p_q <= p_q + PW'(1);
				end
			end
			if (em_issue) begin
				k_q <= k_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_r_s1    <= r_q[RW-1:0];
		rd_last_s1 <= ((RCW+1)'(r_q) + (RCW+1)'(1)) == (RCW+1)'(nr);
		em_last_s1 <= ((CNTW+1)'(k_q) + (CNTW+1)'(1)) == (CNTW+1)'(np);

		if ((state_q == bsc_pkg::ST_IDLE) && go) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				work_q[i] <= WW'(avail[i]);
			end
		end else if ((state_q == bsc_pkg::ST_ADD) && rd_vld_s1) begin
			work_q[rd_r_s1] <= work_q[rd_r_s1] + WW'(alloc_s1);
		end

		if (em_vld_s1) begin
			result_q.safe            <= 1'b1;
			result_q.granted_process <= 4'(seq_rdata);
			result_q.last            <= em_last_s1;
		end else begin
			result_q.safe            <= 1'b0;
			result_q.granted_process <= '0;
			result_q.last            <= 1'b1;
		end
	end

	bsc_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_PROCESSES)
	) u_seq_ram (
		.clk   (clk),
		.we    (grant),
		.waddr (count_q[PW-1:0]),
		.wdata (p_q),
		.raddr (k_q[PW-1:0]),
		.rdata (seq_rdata)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[design/bankers_safety_check_core.sv]
// Banker's safety check core: config registers, load decode, table RAM and scan sequencer.
// Loads are taken back to back while not busy and give no result; a check holds busy until done.
// Scan: a finished process is skipped, an open one has its row tested through the single table
// read port and read again to add its allocation when granted; np results then strobe one per
// cycle, or one unsafe result after the scan. Results cannot be stalled.
// Reset sets both counts to 1 and clears control, not the tables. Depends on bsc_pkg, bsc_ram, bsc_scan.
module bankers_safety_check_core #(
	parameter int MAX_PROCESSES = 16,
	parameter int MAX_RESOURCES = 8,
	parameter int AMOUNT_WIDTH  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bsc_pkg::request_t                   request,
	output logic                                result_valid,
	output bsc_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [bsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int CNTW   = $clog2(MAX_PROCESSES+1);
	localparam int RCW    = $clog2(MAX_RESOURCES+1);
	localparam int TDEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	logic [4:0] num_processes_q;
	logic [3:0] num_resources_q;

	logic [CNTW-1:0] np;
	logic [RCW-1:0]  nr;

	logic [MAX_RESOURCES-1:0][AMOUNT_WIDTH-1:0] avail_q;

	logic                    transfer;
	logic                    go;
	logic                    entry_ok;
	logic                    avail_ok;
	logic                    tbl_we;
	logic [TW-1:0]           tbl_waddr;
	logic [TW-1:0]           tbl_raddr;
	logic [2*AMOUNT_WIDTH-1:0] tbl_wdata;
	logic [2*AMOUNT_WIDTH-1:0] tbl_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_processes_q <= 5'd1;
			num_resources_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bsc_pkg::CFG_NUM_PROCESSES: num_processes_q <= cfg_data;
				bsc_pkg::CFG_NUM_RESOURCES: num_resources_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// saturate the counts into 1..max
	always_comb begin
		if (num_processes_q == '0) begin
			np = CNTW'(1);
		end else if (int'(num_processes_q) > MAX_PROCESSES) begin
			np = CNTW'(MAX_PROCESSES);
		end else begin
			np = CNTW'(num_processes_q);
		end
		if (num_resources_q == '0) begin
			nr = RCW'(1);
		end else if (int'(num_resources_q) > MAX_RESOURCES) begin
			nr = RCW'(MAX_RESOURCES);
		end else begin
			nr = RCW'(num_resources_q);
		end
	end

	assign transfer = start && !busy;
	assign go       = transfer && (request.command == bsc_pkg::CMD_CHECK);
	assign entry_ok = (int'(request.process_index) < MAX_PROCESSES)
		&& (int'(request.resource_index) < MAX_RESOURCES);
	assign avail_ok = int'(request.resource_index) < MAX_RESOURCES;

	assign tbl_we    = transfer && (request.command == bsc_pkg::CMD_LOAD_ENTRY) && entry_ok;
	assign tbl_waddr = TW'(int'(request.process_index) * MAX_RESOURCES
		+ int'(request.resource_index));
	assign tbl_wdata = {AMOUNT_WIDTH'(request.alloc_value), AMOUNT_WIDTH'(request.max_value)};

	always_ff @(posedge clk) begin
		if (transfer && (request.command == bsc_pkg::CMD_LOAD_AVAIL) && avail_ok) begin
			avail_q[RW'(request.resource_index)] <= AMOUNT_WIDTH'(request.avail_value);
		end
	end

	bsc_ram #(
		.WIDTH(2*AMOUNT_WIDTH),
		.DEPTH(TDEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	bsc_scan #(
		.MAX_PROCESSES(MAX_PROCESSES),
		.MAX_RESOURCES(MAX_RESOURCES),
		.AMOUNT_WIDTH (AMOUNT_WIDTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.np           (np),
		.nr           (nr),
		.avail        (avail_q),
		.tbl_raddr    (tbl_raddr),
		.tbl_rdata    (tbl_rdata),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
